// ----- rtl/core/bmpq_pkg.sv -----
// Package for the binned message priority queue.
// Payload structs, command/status codes, sequencer states and defaults.
// No dependencies.
package bmpq_pkg;

  localparam int DefLevels   = 16;
  localparam int DefCapacity = 64;
  localparam int DefTagBits  = 16;
  localparam int MapCount    = 7;
  localparam int CfgIdxBits  = 3;
  localparam int CfgDataBits = 37;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_TAKE_ANY = 2'd1,
    CMD_TAKE_ID  = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_RSVD      = 2'd3
  } status_t;

  localparam logic [CfgIdxBits-1:0] RegDefault = 3'd0;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] msg_id;
    logic [15:0] msg_tag;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] out_id;
    logic [15:0] out_tag;
    logic [3:0]  out_level;
    logic        now_empty;
  } out_item_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic [1:0]  cmd;
    logic [31:0] msg_id;
    logic [15:0] msg_tag;
    logic [3:0]  level;
  } req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_LINK,
    S_RESULT
  } seq_state_t;

endpackage

// ----- rtl/core/binned_message_priority_queue.sv -----
// Binned message priority queue, top level: front classifier plus back store.
// Depends on bmpq_pkg, bmpq_front and bmpq_back.
// One request is in service at a time; the next one starts the cycle after its result
// leaves, and a two-entry queue takes new requests meanwhile. Take-by-id walks the
// level's list one entry per read, stepping through S_CHECK and S_LINK.
// Reset: synchronous active-low, store empty, regs zero.
module binned_message_priority_queue #(
  parameter int LEVELS   = bmpq_pkg::DefLevels,
  parameter int CAPACITY = bmpq_pkg::DefCapacity,
  parameter int TAG_BITS = bmpq_pkg::DefTagBits
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bmpq_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bmpq_pkg::out_item_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [bmpq_pkg::CfgIdxBits-1:0]  cfg_index,
  input  logic [bmpq_pkg::CfgDataBits-1:0] cfg_data
);
  import bmpq_pkg::*;

  logic q_valid, q_ready;
  req_t q_data;

  bmpq_front #(.LEVELS(LEVELS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .q_valid, .q_ready, .q_data
  );

  bmpq_back #(.LEVELS(LEVELS), .CAPACITY(CAPACITY), .TAG_BITS(TAG_BITS)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_data,
    .out_valid, .out_ready, .out_data
  );

endmodule

// ----- rtl/core/bmpq_front.sv -----
// Front end: holds the config registers, maps each request id to its level
// and pushes the classified request into a two-entry queue. Uses bmpq_pkg.
module bmpq_front #(
  parameter int LEVELS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  bmpq_pkg::in_item_t                  in_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmpq_pkg::CfgIdxBits-1:0]     cfg_index,
  input  logic [bmpq_pkg::CfgDataBits-1:0]    cfg_data,
  output logic                                q_valid,
  input  logic                                q_ready,
  output bmpq_pkg::req_t                      q_data
);
  import bmpq_pkg::*;

  logic [3:0]  default_prio_r;
  logic [36:0] map_r [MapCount];
  req_t        fifo_r [2];
  logic        rd_ptr_r, wr_ptr_r;
  logic [1:0]  cnt_r;
  logic [3:0]  lv_raw;
  logic [3:0]  lv_sat;
  logic        found;
  req_t        req;
  logic        push, pop;

  assign cfg_ready = 1'b1;

  // Config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      default_prio_r <= '0;
      for (int i = 0; i < MapCount; i++) map_r[i] <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == RegDefault) default_prio_r <= cfg_data[3:0];
      for (int i = 0; i < MapCount; i++)
        if (cfg_index == CfgIdxBits'(i + 1)) map_r[i] <= cfg_data;
    end
  end

  // First matching valid map entry wins
  always_comb begin
    lv_raw = default_prio_r;
    found  = 1'b0;
    for (int i = 0; i < MapCount; i++) begin
      if (!found && map_r[i][36] && map_r[i][31:0] == in_data.msg_id) begin
        lv_raw = map_r[i][35:32];
        found  = 1'b1;
      end
    end
    if (32'(lv_raw) >= LEVELS) lv_sat = 4'(LEVELS - 1);
    else lv_sat = lv_raw;
    req.cmd     = in_data.cmd;
    req.msg_id  = in_data.msg_id;
    req.msg_tag = in_data.msg_tag;
    req.level   = lv_sat;
  end

  // Two-entry request queue
  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_data   = fifo_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) fifo_r[wr_ptr_r] <= req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

  // Queue never exceeds its depth
  assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("request queue overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !pop) |=> cnt_r == 2'd2)
    else $error("queue count lost");
  assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> 32'(q_data.level) < LEVELS)
    else $error("level beyond range");

endmodule

// ----- rtl/core/bmpq_back.sv -----
// Back end: slot store and per-level linked lists, one request at a time.
// Walks a level's list one slot per S_CHECK/S_LINK pair for take-by-id. Uses bmpq_pkg.
module bmpq_back #(
  parameter int LEVELS   = 16,
  parameter int CAPACITY = 64,
  parameter int TAG_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  bmpq_pkg::req_t       q_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bmpq_pkg::out_item_t  out_data
);
  import bmpq_pkg::*;

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Slot memory: id, tag and next pointer
  logic [31:0]       mem_id   [CAPACITY];
  logic [TAG_BITS-1:0] mem_tag [CAPACITY];
  logic [SW-1:0]     mem_next [CAPACITY];
  logic [SW-1:0]     head_r [LEVELS];
  logic [SW-1:0]     tail_r [LEVELS];

  logic [CAPACITY-1:0] free_r;
  logic [LEVELS-1:0]   nonempty_r;
  logic [CW-1:0]       count_r, count_nxt;
  seq_state_t          state_r, state_nxt;
  req_t                req_r;
  logic [LW-1:0]       lv_r;
  logic [SW-1:0]       cur_r, cur_nxt, prev_r, prev_nxt;
  logic                has_prev_r, has_prev_nxt;
  logic [31:0]         rd_id_r;
  logic [TAG_BITS-1:0] rd_tag_r;
  logic [SW-1:0]       rd_next_r;
  out_item_t           res_r, res_nxt;

  logic                mem_we;
  logic [SW-1:0]       mem_wa;
  logic                nxt_we;
  logic [SW-1:0]       nxt_wa, nxt_wd;
  logic [SW-1:0]       free_slot;
  logic                any_free;
  logic [LW-1:0]       min_lv;
  logic                any_ne;
  logic                accept;

  assign q_ready   = (state_r == S_IDLE);
  assign accept    = q_valid && q_ready;
  assign out_valid = (state_r == S_RESULT);
  assign out_data  = res_r;

  // Lowest free slot and lowest nonempty level
  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = CAPACITY - 1; i >= 0; i--)
      if (free_r[i]) begin
        free_slot = SW'(i);
        any_free  = 1'b1;
      end
    min_lv = '0;
    any_ne = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--)
      if (nonempty_r[i]) begin
        min_lv = LW'(i);
        any_ne = 1'b1;
      end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_READ;
      S_READ: begin
        priority if (req_r.cmd == CMD_TAKE_ID && nonempty_r[lv_r]) state_nxt = S_CHECK;
        else if (req_r.cmd == CMD_TAKE_ANY && any_ne) state_nxt = S_CHECK;
        else state_nxt = S_RESULT;
      end
      S_CHECK: begin
        priority if (req_r.cmd == CMD_TAKE_ANY) state_nxt = S_RESULT;
        else if (rd_id_r == req_r.msg_id) state_nxt = S_RESULT;
        else if (tail_r[lv_r] == cur_r) state_nxt = S_RESULT;
        else state_nxt = S_LINK;
      end
      S_LINK:   state_nxt = S_CHECK;
      S_RESULT: if (out_ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // Datapath outputs of the sequencer
  always_comb begin
    res_nxt      = res_r;
    cur_nxt      = cur_r;
    prev_nxt     = prev_r;
    has_prev_nxt = has_prev_r;
    count_nxt    = count_r;
    mem_we = 1'b0;
    mem_wa = free_slot;
    nxt_we = 1'b0;
    nxt_wa = '0;
    nxt_wd = '0;
    unique case (state_r)
      S_IDLE: begin
        res_nxt = '0;
        res_nxt.status = ST_NOT_FOUND;
        has_prev_nxt = 1'b0;
      end
      S_READ: begin
        res_nxt.now_empty = (count_r == '0);
        unique case (req_r.cmd)
          CMD_INSERT: begin
            res_nxt.out_level = 4'(lv_r);
            if (count_r >= CW'(CAPACITY) || !any_free) begin
              res_nxt.status = ST_FULL;
            end else begin
              res_nxt.status = ST_DONE;
              mem_we = 1'b1;
              if (nonempty_r[lv_r]) begin
                nxt_we = 1'b1;
                nxt_wa = tail_r[lv_r];
                nxt_wd = free_slot;
              end
              count_nxt = count_r + 1'b1;
              res_nxt.now_empty = 1'b0;
            end
          end
          CMD_TAKE_ANY: cur_nxt = head_r[min_lv];
          CMD_TAKE_ID: begin
            res_nxt.out_level = 4'(lv_r);
            cur_nxt = head_r[lv_r];
          end
          default: res_nxt.out_level = '0;
        endcase
      end
      S_CHECK: begin
        if (req_r.cmd == CMD_TAKE_ANY || rd_id_r == req_r.msg_id) begin
          res_nxt.status  = ST_DONE;
          res_nxt.out_id  = rd_id_r;
          res_nxt.out_tag = 16'(rd_tag_r);
          res_nxt.out_level = 4'(lv_r);
          count_nxt = count_r - 1'b1;
          res_nxt.now_empty = (count_r == CW'(1));
          if (has_prev_r) begin
            nxt_we = 1'b1;
            nxt_wa = prev_r;
            nxt_wd = rd_next_r;
          end
        end else begin
          prev_nxt     = cur_r;
          has_prev_nxt = 1'b1;
          cur_nxt      = rd_next_r;
        end
      end
      S_LINK, S_RESULT: ;
      default: ;
    endcase
  end

  // Level of the request being served
  logic [LW-1:0] take_lv;
  assign take_lv = (req_r.cmd == CMD_TAKE_ANY) ? min_lv : LW'(req_r.level);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      free_r     <= '1;
      nonempty_r <= '0;
      count_r    <= '0;
      has_prev_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      has_prev_r <= has_prev_nxt;
      if (state_r == S_READ && mem_we) begin
        free_r[free_slot] <= 1'b0;
        nonempty_r[lv_r]  <= 1'b1;
      end
      if (state_r == S_CHECK && res_nxt.status == ST_DONE) begin
        free_r[cur_r] <= 1'b1;
        if (!has_prev_r && tail_r[lv_r] == cur_r) nonempty_r[lv_r] <= 1'b0;
      end
    end
  end

  // Payload registers, list pointers and slot memory
  always_ff @(posedge clk) begin
    if (accept) req_r <= q_data;
    if (accept) lv_r <= LW'(q_data.level);
    else if (state_r == S_READ) lv_r <= take_lv;
    res_r    <= res_nxt;
    cur_r    <= cur_nxt;
    prev_r   <= prev_nxt;
    if (mem_we) begin
      mem_id[mem_wa]   <= req_r.msg_id;
      mem_tag[mem_wa]  <= TAG_BITS'(req_r.msg_tag);
      mem_next[mem_wa] <= '0;
    end
    if (nxt_we) mem_next[nxt_wa] <= nxt_wd;
    // registered read of the slot under inspection
    rd_id_r   <= mem_id[cur_nxt];
    rd_tag_r  <= mem_tag[cur_nxt];
    rd_next_r <= mem_next[cur_nxt];
    if (state_r == S_READ && mem_we) begin
      tail_r[lv_r] <= free_slot;
      if (!nonempty_r[lv_r]) head_r[lv_r] <= free_slot;
    end
    if (state_r == S_CHECK && res_nxt.status == ST_DONE) begin
      if (!has_prev_r) head_r[lv_r] <= rd_next_r;
      else if (tail_r[lv_r] == cur_r) tail_r[lv_r] <= prev_r;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("stored count beyond capacity");
  assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (nonempty_r == '0))
    else $error("nonempty level while store empty");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RESULT && !out_ready) |=> state_r == S_RESULT && $stable(res_r))
    else $error("result lost under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LINK) |=> state_r == S_CHECK)
    else $error("walk step skipped");

endmodule

// ----- tb/bmpq_checker.sv -----
// Result checker for the binned message priority queue.
// Watches the request, result and register-write channels and predicts each result.
// Depends on bmpq_pkg.
`timescale 1ns / 100ps
module bmpq_checker
  import bmpq_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_ready,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_ready,
  input  out_item_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CfgIdxBits-1:0]  cfg_index,
  input  logic [CfgDataBits-1:0] cfg_data,
  output int                     fail_count,
  output int                     pending_count
);

  localparam int NLev = 16;
  localparam int NCap = 64;

  // predictor copy of the register file and the store
  logic [3:0]  dflt_level;
  logic [36:0] id_map [MapCount];
  logic [31:0] q_id   [NCap];
  logic [15:0] q_tag  [NCap];
  logic [5:0]  q_next [NCap];
  logic        q_free [NCap];
  logic [5:0]  bin_head [NLev];
  logic [5:0]  bin_tail [NLev];
  logic        bin_used [NLev];
  int          msg_count;

  out_item_t expected_results [$];

  assign pending_count = expected_results.size();

  function automatic logic [3:0] level_of(logic [31:0] id);
    logic [3:0] lv;
    lv = dflt_level;
    for (int i = MapCount - 1; i >= 0; i--)
      if (id_map[i][36] && id_map[i][31:0] == id) lv = id_map[i][35:32];
    return lv;
  endfunction

  // apply one request to the predicted store and return its result
  function automatic out_item_t queue_step(in_item_t rq);
    out_item_t r;
    logic [3:0] lv;
    int s, cur, prev;
    bit found;
    r = '0;
    r.status = ST_NOT_FOUND;
    case (cmd_t'(rq.cmd))
      CMD_INSERT: begin
        lv = level_of(rq.msg_id);
        r.out_level = lv;
        if (msg_count >= NCap) begin
          r.status = ST_FULL;
        end else begin
          s = 0;
          while (!q_free[s]) s++;
          q_free[s] = 1'b0;
          q_id[s] = rq.msg_id;
          q_tag[s] = rq.msg_tag;
          q_next[s] = '0;
          if (bin_used[lv]) begin
            q_next[bin_tail[lv]] = s[5:0];
            bin_tail[lv] = s[5:0];
          end else begin
            bin_head[lv] = s[5:0];
            bin_tail[lv] = s[5:0];
            bin_used[lv] = 1'b1;
          end
          msg_count++;
          r.status = ST_DONE;
        end
      end
      CMD_TAKE_ANY: begin
        for (int l = 0; l < NLev; l++)
          if (bin_used[l] && r.status != ST_DONE) begin
            cur = bin_head[l];
            r.out_id = q_id[cur];
            r.out_tag = q_tag[cur];
            r.out_level = l[3:0];
            r.status = ST_DONE;
            if (bin_tail[l] == cur) bin_used[l] = 1'b0;
            else bin_head[l] = q_next[cur];
            q_free[cur] = 1'b1;
            msg_count--;
          end
      end
      CMD_TAKE_ID: begin
        lv = level_of(rq.msg_id);
        r.out_level = lv;
        if (bin_used[lv]) begin
          cur = bin_head[lv];
          prev = -1;
          found = 0;
          for (int n = 0; n < NCap && !found; n++) begin
            if (q_id[cur] == rq.msg_id) begin
              found = 1;
              r.out_id = q_id[cur];
              r.out_tag = q_tag[cur];
              r.status = ST_DONE;
              if (prev < 0) begin
                if (bin_tail[lv] == cur) bin_used[lv] = 1'b0;
                else bin_head[lv] = q_next[cur];
              end else begin
                q_next[prev] = q_next[cur];
                if (bin_tail[lv] == cur) bin_tail[lv] = prev[5:0];
              end
              q_free[cur] = 1'b1;
              msg_count--;
            end else if (bin_tail[lv] == cur) begin
              n = NCap;
            end else begin
              prev = cur;
              cur = q_next[cur];
            end
          end
        end
      end
      default: ;
    endcase
    r.now_empty = (msg_count == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      dflt_level = '0;
      for (int i = 0; i < MapCount; i++) id_map[i] = '0;
      for (int i = 0; i < NCap; i++) q_free[i] = 1'b1;
      for (int i = 0; i < NLev; i++) bin_used[i] = 1'b0;
      msg_count = 0;
      fail_count = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == RegDefault) dflt_level = cfg_data[3:0];
        else id_map[cfg_index - 1] = cfg_data;
      end
      if (in_valid && in_ready) expected_results.push_back(queue_step(in_data));
      // compare the result against the oldest prediction
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result %p", out_data);
        end else begin
          want = expected_results.pop_front();
          if (want !== out_data) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p got %p", want, out_data);
          end
        end
      end
    end
  end

endmodule

// ----- tb/tb_binned_message_priority_queue.sv -----
// Testbench top for the binned message priority queue: stimulus and verdict.
// Depends on bmpq_pkg, bmpq_checker and the queue RTL.
`timescale 1ns / 100ps
module tb_binned_message_priority_queue;
  import bmpq_pkg::*;

  localparam int StallLimit = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  int fail_count, pending_count;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_off = 0;
  int quiet_cycles = 0;
  logic [31:0] id_pool [8];
  logic [31:0] sent_ids [$];

  always #10 clk = ~clk;

  binned_message_priority_queue u_top (.*);

  bmpq_checker u_chk (.*);

  // receiver: random stalls, or a long hold-off while stimulus keeps coming
  always @(posedge clk) begin
    if (hold_off) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on cycles with no accepted transfer
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > StallLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // valid stays up between back-to-back requests; idle cycles and drain() drop it
  task automatic send_request(cmd_t c, logic [31:0] id, logic [15:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{cmd: c, msg_id: id, msg_tag: tag};
    do @(posedge clk); while (!in_ready);
  endtask

  // valid stays up between writes; program_map() drops it at the end
  task automatic write_reg(logic [CfgIdxBits-1:0] idx, logic [CfgDataBits-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // map setup: pick ids and levels, including level extremes and, in phase 1, an invalid entry
  task automatic program_map(int phase);
    logic [3:0] lv;
    write_reg(RegDefault, CfgDataBits'((phase == 0) ? 4'd15 : 4'($urandom_range(15))));
    for (int i = 0; i < MapCount; i++) begin
      lv = (i == 0) ? 4'd0 : (i == 1) ? 4'd15 : 4'($urandom_range(15));
      write_reg(CfgIdxBits'(i + 1), {1'b1 ^ (i == 6 && phase == 1), lv, id_pool[i]});
    end
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_id();
    if ($urandom_range(3) == 0) return $urandom;
    return id_pool[$urandom_range(7)];
  endfunction

  task automatic random_burst(int count);
    int k;
    logic [31:0] id;
    for (int n = 0; n < count; n++) begin
      k = $urandom_range(99);
      if (k < 45) begin
        id = pick_id();
        sent_ids.push_back(id);
        send_request(CMD_INSERT, id, 16'($urandom));
      end else if (k < 70) begin
        send_request(CMD_TAKE_ANY, $urandom, 16'($urandom));
      end else if (k < 96) begin
        id = (sent_ids.size() != 0 && $urandom_range(3) != 0)
             ? sent_ids[$urandom_range(sent_ids.size() - 1)] : pick_id();
        send_request(CMD_TAKE_ID, id, 16'($urandom));
      end else begin
        send_request(CMD_UNUSED, $urandom, 16'($urandom));
      end
    end
  endtask

  initial begin
    int pct [4][2] = '{'{0, 0}, '{88, 0}, '{0, 88}, '{34, 34}};
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) id_pool[i] = $urandom;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty takes, unused command, extremes, mapped levels, default
    send_request(CMD_TAKE_ANY, 32'h0, 16'h0);
    send_request(CMD_TAKE_ID, 32'h5, 16'h0);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CMD_INSERT, 32'hFFFF_FFFF, 16'hFFFF);
    send_request(CMD_INSERT, 32'h0, 16'h0);
    send_request(CMD_TAKE_ID, 32'hFFFF_FFFF, 16'h0);
    send_request(CMD_TAKE_ANY, 32'h0, 16'h0);
    drain();
    program_map(0);
    for (int i = 0; i < 8; i++) send_request(CMD_INSERT, id_pool[i], 16'(i * 16'h2111));
    send_request(CMD_TAKE_ID, id_pool[3], 16'h0);
    send_request(CMD_TAKE_ID, 32'h1234_5678, 16'h0);
    for (int i = 0; i < 8; i++) send_request(CMD_TAKE_ANY, 32'h0, 16'h0);
    drain();

    // fill past capacity with the receiver held off so the input stalls
    fork
      begin
        hold_off = 1;
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 66; i++) send_request(CMD_INSERT, pick_id(), 16'($urandom));
    join
    for (int i = 0; i < 66; i++) send_request(CMD_TAKE_ANY, 32'h0, 16'h0);
    drain();

    // random phases, each with its own map settings and idle mix
    for (int p = 0; p < 4; p++) begin
      program_map(p == 2 ? 0 : 1);
      send_idle_pct = pct[p][0];
      recv_stall_pct = pct[p][1];
      random_burst(240);
      drain();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    if (fail_count == 0 && pending_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
